>>> hw/rtl/pscp_pkg.sv
package pscp_pkg;

  typedef enum logic [5:0] {
    ST_IDLE      = 6'd0,
    ST_C         = 6'd1,
    ST_CO        = 6'd2,
    ST_CON       = 6'd3,
    ST_CONN      = 6'd4,
    ST_CONNE     = 6'd5,
    ST_CONNEC    = 6'd6,
    ST_CONNECT   = 6'd7,
    ST_CONN_ARG  = 6'd8,
    ST_P         = 6'd9,
    ST_PI        = 6'd10,
    ST_PIN       = 6'd11,
    ST_PING      = 6'd12,
    ST_PO        = 6'd13,
    ST_PON       = 6'd14,
    ST_PONG      = 6'd15,
    ST_S         = 6'd16,
    ST_SU        = 6'd17,
    ST_SUB       = 6'd18,
    ST_SUB_SPC   = 6'd19,
    ST_SUB_ARG   = 6'd20,
    ST_PU        = 6'd21,
    ST_PUB       = 6'd22,
    ST_PUB_SPC   = 6'd23,
    ST_PUB_ARG   = 6'd24,
    ST_PAYLOAD   = 6'd25,
    ST_END_R     = 6'd26,
    ST_END_N     = 6'd27
  } parse_state_t;

  localparam logic [2:0] EV_ARG     = 3'd0;
  localparam logic [2:0] EV_PAYLOAD = 3'd1;
  localparam logic [2:0] EV_HEADER  = 3'd2;
  localparam logic [2:0] EV_DONE    = 3'd3;
  localparam logic [2:0] EV_ERROR   = 3'd4;

  localparam logic [2:0] CMD_CONNECT = 3'd0;
  localparam logic [2:0] CMD_PING    = 3'd1;
  localparam logic [2:0] CMD_PONG    = 3'd2;
  localparam logic [2:0] CMD_SUB     = 3'd3;
  localparam logic [2:0] CMD_PUB     = 3'd4;

  localparam logic [1:0] ERR_KEYWORD   = 2'd0;
  localparam logic [1:0] ERR_SEPARATOR = 2'd1;
  localparam logic [1:0] ERR_TRAILER   = 2'd2;
  localparam logic [1:0] ERR_LENGTH    = 2'd3;

  localparam logic [7:0] CH_SP = 8'h20;
  localparam logic [7:0] CH_HT = 8'h09;
  localparam logic [7:0] CH_CR = 8'h0d;
  localparam logic [7:0] CH_LF = 8'h0a;

  localparam int unsigned MAX_PAYLOAD_RESET = 1048576;

  typedef struct packed {
    logic [2:0]  event_kind;
    logic [2:0]  command;
    logic [2:0]  token_index;
    logic        token_start;
    logic [7:0]  value_byte;
    logic [2:0]  token_count;
    logic [25:0] payload_length;
    logic [1:0]  error_reason;
    logic [5:0]  error_state;
  } result_t;

  // keyword letter expected in a linear keyword state, zero when none
  function automatic logic [7:0] kw_char(input parse_state_t st);
    case (st)
      ST_C:      kw_char = "o";
      ST_CO:     kw_char = "n";
      ST_CON:    kw_char = "n";
      ST_CONN:   kw_char = "e";
      ST_CONNE:  kw_char = "c";
      ST_CONNEC: kw_char = "t";
      ST_PI:     kw_char = "n";
      ST_PIN:    kw_char = "g";
      ST_PO:     kw_char = "n";
      ST_PON:    kw_char = "g";
      ST_S:      kw_char = "u";
      ST_SU:     kw_char = "b";
      ST_PU:     kw_char = "b";
      default:   kw_char = 8'd0;
    endcase
  endfunction

endpackage

>>> hw/rtl/pscp_stream_if.sv
interface pscp_stream_if #(
  parameter int unsigned WIDTH = 8
) ();
  logic             valid;
  logic             ready;
  logic [WIDTH-1:0] payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

>>> hw/rtl/pscp_len_acc.sv
// Decimal length accumulator, saturating at 2**LENGTH_BITS.
module pscp_len_acc #(
  parameter int unsigned LENGTH_BITS = 26
) (
  input  logic [LENGTH_BITS:0] acc,
  input  logic [7:0]           digit_byte,
  output logic                 is_digit,
  output logic [LENGTH_BITS:0] acc_nxt
);
  localparam logic [LENGTH_BITS:0] CAP = {1'b1, {LENGTH_BITS{1'b0}}};
  logic [LENGTH_BITS+4:0] prod;

  always_comb begin
    is_digit = (digit_byte >= "0") && (digit_byte <= "9");
    prod = ({4'd0, acc} << 3) + ({4'd0, acc} << 1)
         + {{(LENGTH_BITS+1){1'b0}}, digit_byte[3:0]};
    if (!is_digit) begin
      acc_nxt = CAP;
    end else if (prod > {4'd0, CAP}) begin
      acc_nxt = CAP;
    end else begin
      acc_nxt = prod[LENGTH_BITS:0];
    end
  end
endmodule

>>> hw/rtl/pscp_core.sv
// One byte step of the recognizer; state and result register updates.
module pscp_core #(
  parameter int unsigned LENGTH_BITS = 26,
  parameter int unsigned TOKEN_LIMIT = 7
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   step,
  input  logic [7:0]             b,
  input  logic [LENGTH_BITS-1:0] max_payload,
  output logic                   res_valid,
  output pscp_pkg::result_t      res
);
  import pscp_pkg::*;

  localparam int unsigned TW = $clog2(TOKEN_LIMIT + 1);
  localparam logic [TW-1:0] TLIM = TW'(TOKEN_LIMIT);

  parse_state_t           st_r, st_nxt;
  logic [2:0]             cmd_r, cmd_nxt;
  logic [TW-1:0]          tcnt_r, tcnt_nxt, tcur_r, tcur_nxt;
  logic                   intok_r, intok_nxt;
  logic [LENGTH_BITS:0]   v2_r, v2_nxt, v3_r, v3_nxt;
  logic [1:0]             dig_r, dig_nxt;
  logic [LENGTH_BITS-1:0] rem_r, rem_nxt;

  logic [7:0]           low;
  logic                 blank;
  logic                 d2, d3;
  logic [LENGTH_BITS:0] a2, a3, sel_len;
  logic                 emit;
  result_t              r;

  pscp_len_acc #(.LENGTH_BITS(LENGTH_BITS)) u_acc2 (
    .acc(v2_r), .digit_byte(b), .is_digit(d2), .acc_nxt(a2));
  pscp_len_acc #(.LENGTH_BITS(LENGTH_BITS)) u_acc3 (
    .acc(v3_r), .digit_byte(b), .is_digit(d3), .acc_nxt(a3));

  function automatic logic [2:0] sat3(input logic [TW-1:0] v);
    sat3 = (32'(v) > 7) ? 3'd7 : 3'(v);
  endfunction

  always_comb begin
    logic sep;
    logic [TW-1:0] cur;
    logic [1:0] bitm;
    logic [LENGTH_BITS:0] len;
    sep = 1'b0; cur = tcur_r; bitm = 2'd0; len = '0;
    low = b | 8'h20;
    blank = (b == CH_SP) || (b == CH_HT);
    sel_len = (tcnt_r == TW'(2)) ? v2_r : v3_r;
    st_nxt = st_r; cmd_nxt = cmd_r; tcnt_nxt = tcnt_r; tcur_nxt = tcur_r;
    intok_nxt = intok_r; v2_nxt = v2_r; v3_nxt = v3_r; dig_nxt = dig_r;
    rem_nxt = rem_r;
    emit = 1'b0;
    r = '0;

    if (kw_char(st_r) != 8'd0) begin
      if (low != kw_char(st_r)) begin
        emit = 1'b1; r.event_kind = EV_ERROR; r.error_reason = ERR_KEYWORD;
        r.error_state = st_r;
      end else begin
        st_nxt = parse_state_t'(st_r + 6'd1);
      end
    end else begin
      unique case (st_r)
        ST_IDLE: begin
          if (low == "c") begin
            st_nxt = ST_C; cmd_nxt = CMD_CONNECT;
          end else if (low == "p") begin
            st_nxt = ST_P;
          end else if (low == "s") begin
            st_nxt = ST_S; cmd_nxt = CMD_SUB;
          end else begin
            emit = 1'b1; r.event_kind = EV_ERROR; r.error_reason = ERR_KEYWORD;
            r.error_state = st_r;
          end
        end
        ST_P: begin
          if (low == "i") begin
            st_nxt = ST_PI; cmd_nxt = CMD_PING;
          end else if (low == "o") begin
            st_nxt = ST_PO; cmd_nxt = CMD_PONG;
          end else if (low == "u") begin
            st_nxt = ST_PU; cmd_nxt = CMD_PUB;
          end else begin
            emit = 1'b1; r.event_kind = EV_ERROR; r.error_reason = ERR_KEYWORD;
            r.error_state = st_r;
          end
        end
        ST_CONNECT: begin
          if (blank) st_nxt = ST_CONN_ARG;
        end
        ST_PING, ST_PONG: begin
          if (b == CH_LF) begin
            emit = 1'b1; r.event_kind = EV_DONE; r.command = cmd_r;
            st_nxt = ST_IDLE;
          end
        end
        ST_SUB, ST_PUB: begin
          if (!blank) begin
            emit = 1'b1; r.event_kind = EV_ERROR; r.error_reason = ERR_SEPARATOR;
            r.error_state = st_r;
          end else begin
            st_nxt = parse_state_t'(st_r + 6'd1);
          end
        end
        ST_SUB_SPC, ST_PUB_SPC, ST_CONN_ARG, ST_SUB_ARG, ST_PUB_ARG: begin
          if ((st_r == ST_SUB_SPC || st_r == ST_PUB_SPC) && blank) begin
            // skip leading blanks
          end else begin
            if (st_r == ST_SUB_SPC || st_r == ST_PUB_SPC)
              st_nxt = parse_state_t'(st_r + 6'd1);
            if (b == CH_LF) begin
              if (cmd_r == CMD_PUB) begin
                bitm = (tcnt_r == TW'(2)) ? 2'b01 : 2'b10;
                len = sel_len;
                if (tcnt_r < TW'(2) || (dig_r & bitm) == 2'b00
                    || len > {1'b0, max_payload}) begin
                  // reported from the argument state, even on the first byte
                  emit = 1'b1; r.event_kind = EV_ERROR;
                  r.error_reason = ERR_LENGTH; r.error_state = st_nxt;
                end else begin
                  emit = 1'b1; r.event_kind = EV_HEADER; r.command = CMD_PUB;
                  r.token_count = sat3(tcnt_r);
                  r.payload_length = 26'(len);
                  rem_nxt = len[LENGTH_BITS-1:0];
                  st_nxt = (len == '0) ? ST_END_R : ST_PAYLOAD;
                end
              end else begin
                emit = 1'b1; r.event_kind = EV_DONE; r.command = cmd_r;
                r.token_count = sat3(tcnt_r);
                st_nxt = ST_IDLE;
              end
            end else if (b == CH_CR && cmd_r == CMD_CONNECT) begin
              // dropped
            end else begin
              if (cmd_r == CMD_SUB) sep = blank || (b == CH_CR);
              else if (cmd_r == CMD_PUB) sep = (b == CH_SP) || (b == CH_CR);
              if (sep) begin
                intok_nxt = 1'b0;
              end else begin
                if (!intok_r) begin
                  cur = (tcnt_r < TLIM) ? tcnt_r : TLIM;
                  tcnt_nxt = (tcnt_r < TLIM) ? tcnt_r + TW'(1) : TLIM;
                  intok_nxt = 1'b1;
                  r.token_start = 1'b1;
                end
                tcur_nxt = cur;
                if (cmd_r == CMD_PUB) begin
                  if (cur == TW'(1)) begin
                    v2_nxt = a2; if (d2) dig_nxt[0] = 1'b1;
                  end else if (cur == TW'(2)) begin
                    v3_nxt = a3; if (d3) dig_nxt[1] = 1'b1;
                  end
                end
                emit = 1'b1; r.event_kind = EV_ARG; r.command = cmd_r;
                r.token_index = sat3(cur); r.value_byte = b;
              end
            end
          end
        end
        ST_PAYLOAD: begin
          if (rem_r <= LENGTH_BITS'(1)) st_nxt = ST_END_R;
          if (rem_r != '0) rem_nxt = rem_r - LENGTH_BITS'(1);
          emit = 1'b1; r.event_kind = EV_PAYLOAD; r.command = CMD_PUB; r.value_byte = b;
        end
        ST_END_R: begin
          if (b != CH_CR) begin
            emit = 1'b1; r.event_kind = EV_ERROR; r.error_reason = ERR_TRAILER;
            r.error_state = st_r;
          end else begin
            st_nxt = ST_END_N;
          end
        end
        ST_END_N: begin
          emit = 1'b1;
          if (b != CH_LF) begin
            r.event_kind = EV_ERROR; r.error_reason = ERR_TRAILER;
            r.error_state = st_r;
          end else begin
            r.event_kind = EV_DONE; r.command = CMD_PUB;
            r.token_count = sat3(tcnt_r); r.payload_length = 26'(sel_len);
            st_nxt = ST_IDLE;
          end
        end
        default: st_nxt = ST_IDLE;
      endcase
    end

    if ((emit && r.event_kind == EV_ERROR) || st_nxt == ST_IDLE) begin
      st_nxt = ST_IDLE; cmd_nxt = CMD_CONNECT; tcnt_nxt = '0; tcur_nxt = '0;
      intok_nxt = 1'b0; v2_nxt = '0; v3_nxt = '0; dig_nxt = '0; rem_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE; cmd_r <= CMD_CONNECT; tcnt_r <= '0; tcur_r <= '0;
      intok_r <= 1'b0; v2_r <= '0; v3_r <= '0; dig_r <= '0; rem_r <= '0;
      res_valid <= 1'b0;
    end else begin
      res_valid <= step && emit;
      if (step) begin
        st_r <= st_nxt; cmd_r <= cmd_nxt; tcnt_r <= tcnt_nxt; tcur_r <= tcur_nxt;
        intok_r <= intok_nxt; v2_r <= v2_nxt; v3_r <= v3_nxt; dig_r <= dig_nxt;
        rem_r <= rem_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (step) res <= r;
  end
endmodule

>>> hw/rtl/pscp_out_buf.sv
// Two-entry skid buffer on the result channel.
module pscp_out_buf (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  pscp_pkg::result_t in_data,
  output logic              space_ok,
  pscp_stream_if.source     out_if
);
  import pscp_pkg::*;

  result_t  mem_r [2];
  logic     wp_r, rp_r;
  logic [1:0] cnt_r;
  logic     pop;

  assign pop = out_if.valid && out_if.ready;
  assign out_if.valid = (cnt_r != 2'd0);
  assign out_if.payload = mem_r[rp_r];
  // at most one result in flight from the core, so one free slot is enough
  assign space_ok = (cnt_r == 2'd0) || (cnt_r == 2'd1 && !in_valid) || pop;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0; rp_r <= 1'b0; cnt_r <= 2'd0;
    end else begin
      if (in_valid) wp_r <= ~wp_r;
      if (pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, in_valid} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid) mem_r[wp_r] <= in_data;
  end
endmodule

>>> hw/rtl/pubsub_command_stream_parser.sv
// Byte-serial command parser for a text publish/subscribe protocol.
// in_ch carries one byte per beat (valid/ready). out_ch carries one result
// per beat: argument bytes, payload bytes, header done, command done, error.
// cfg_we/cfg_wdata set the largest accepted payload length (reset 1048576);
// write it only while the block is idle.
// Throughput: one input byte per cycle while in_ch.ready is high. Each byte
// is decoded in a single pass of logic into the result register, which
// moves into a two-entry output buffer on the next edge, from which it
// shows on out_ch.
// Bytes that make no result (keyword letters, CR, separators) only update
// the parser state. At reset the parser is idle and the buffer empty.
// When the receiver stalls, the buffer fills and in_ch.ready drops; no
// result is lost, and the input resumes once a slot frees up.
module pubsub_command_stream_parser #(
  parameter int unsigned LENGTH_BITS = 26,
  parameter int unsigned TOKEN_LIMIT = 7
) (
  input  logic                   clk,
  input  logic                   rst_n,
  pscp_stream_if.sink            in_ch,
  pscp_stream_if.source          out_ch,
  input  logic                   cfg_we,
  input  logic [LENGTH_BITS-1:0] cfg_wdata
);
  import pscp_pkg::*;

  logic [LENGTH_BITS-1:0] max_payload_r;
  logic                   step, res_valid, space_ok;
  result_t                res;

  assign in_ch.ready = space_ok;
  assign step = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) max_payload_r <= LENGTH_BITS'(MAX_PAYLOAD_RESET);
    else if (cfg_we) max_payload_r <= cfg_wdata;
  end

  pscp_core #(.LENGTH_BITS(LENGTH_BITS), .TOKEN_LIMIT(TOKEN_LIMIT)) u_core (
    .clk, .rst_n, .step, .b(in_ch.payload[7:0]), .max_payload(max_payload_r),
    .res_valid, .res);

  pscp_out_buf u_buf (
    .clk, .rst_n, .in_valid(res_valid), .in_data(res), .space_ok,
    .out_if(out_ch));
endmodule

>>> hw/rtl/pscp_checker.sv
module pscp_checker (
  input logic clk,
  input logic rst_n,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic [2:0] out_kind,
  input logic [2:0] out_cmd,
  input logic [1:0] out_reason
);
  import pscp_pkg::*;

  a_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_kind <= EV_ERROR) else $error("bad event kind");
  a_errcmd: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == EV_ERROR |-> out_cmd == CMD_CONNECT)
    else $error("error with command");
  a_reason: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind != EV_ERROR |-> out_reason == ERR_KEYWORD)
    else $error("stray reason");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid) else $error("result dropped");
  a_rdy: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready) else $error("stalled while empty");
endmodule

bind pubsub_command_stream_parser pscp_checker u_chk (
  .clk(clk), .rst_n(rst_n), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .out_kind(out_ch.payload[54:52]), .out_cmd(out_ch.payload[51:49]),
  .out_reason(out_ch.payload[7:6]));
